// ----- hdl/cosine_law_angle_sampler_core_defines.svh -----
// Assertion macros shared by the cosine-law angle sampler modules.
`ifndef COSINE_LAW_ANGLE_SAMPLER_CORE_DEFINES_SVH
`define COSINE_LAW_ANGLE_SAMPLER_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define CLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain condition checked at every clock edge outside reset.
`define CLS_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- hdl/cls_pkg.sv -----
// Package with widths, constants and types of the cosine-law angle sampler.
package cls_pkg;

  // Angle format: degrees with this many fraction bits.
  localparam int ANGLE_FRAC_BITS = 10;
  localparam int ANG_W = ANGLE_FRAC_BITS + 7;
  localparam int OUT_W = ANGLE_FRAC_BITS + 8;

  localparam logic [63:0] DEG90  = 64'(90) << ANGLE_FRAC_BITS;
  localparam logic [63:0] DEG180 = 64'(180) << ANGLE_FRAC_BITS;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Radian conversion: x = a*Q0 + floor(a*R0 / DEG180).
  localparam logic [63:0] RAD_Q0 = PI_Q30 / DEG180;
  localparam logic [63:0] RAD_R0 = PI_Q30 % DEG180;
  localparam int W_P2 = 2 * ANGLE_FRAC_BITS + 15;
  // DEG180 = 45 << (FRAC+2); the remaining divide by 45 is a reciprocal multiply.
  localparam int N45 = ANGLE_FRAC_BITS + 12;
  localparam int S45 = N45 + 6;
  localparam logic [63:0] M45 = ((64'd1 << S45) + 64'd44) / 64'd45;
  localparam int W_M45 = S45 - 4;
  localparam int W_T = N45 + W_M45;

  // Taylor term divisors (2k)(2k+1) = odd << tz; odd part by reciprocal multiply.
  localparam logic [5:0] TAY_TZ [8] = '{6'd1, 6'd2, 6'd1, 6'd3, 6'd1, 6'd2, 6'd1, 6'd4};
  localparam logic [5:0] TAY_S  [8] = '{6'd34, 6'd35, 6'd37, 6'd36,
                                        6'd38, 6'd38, 6'd39, 6'd37};
  localparam logic [63:0] TAY_M [8] = '{
    ((64'd1 << 34) + 64'd2) / 64'd3,
    ((64'd1 << 35) + 64'd4) / 64'd5,
    ((64'd1 << 37) + 64'd20) / 64'd21,
    ((64'd1 << 36) + 64'd8) / 64'd9,
    ((64'd1 << 38) + 64'd54) / 64'd55,
    ((64'd1 << 38) + 64'd38) / 64'd39,
    ((64'd1 << 39) + 64'd104) / 64'd105,
    ((64'd1 << 37) + 64'd16) / 64'd17
  };

  // Pipeline depths.
  localparam int CURVE_LAT = 22;
  localparam int STEP_LAT = CURVE_LAT + 2;
  localparam int BISECT_STEPS = $clog2(int'(DEG90) + 1);
  localparam int TOTAL_LAT = CURVE_LAT + 3 + BISECT_STEPS * STEP_LAT + 1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ANGLE_LOW  = 2'd0,
    CFG_ANGLE_HIGH = 2'd1,
    CFG_FLOW_MODE  = 2'd2,
    CFG_BACKWARD   = 2'd3
  } cfg_idx_t;

  // Item data that travels alongside the sine pipeline.
  typedef struct packed {
    logic [ANG_W-1:0] lo;
    logic [ANG_W-1:0] hi;
    logic [ANG_W-1:0] mid;
    logic [30:0]      target;
    logic [31:0]      u;
  } side_t;

endpackage

// ----- hdl/cosine_law_angle_sampler_core.sv -----
// Top level of the cosine-law polar angle sampler.
//
// Usage: drive a 32-bit uniform fraction on in_uniform_draw with start high;
// the item is taken at every clock edge where start is high and busy is low.
// busy stays low, so a new item may be given in every cycle.
// Each item gives one angle on out_angle_out (degrees, 10 fraction bits),
// shown for one cycle with out_valid high, in order of entry.
// Each item passes the two bound sine pipelines, the uniform draw between
// them, the 17 bisection steps (a sine pipeline per step) and the output
// register. Throughput is one item per cycle.
// Configuration: cfg_we with cfg_index selects angle_low, angle_high,
// flow_mode or backward; bounds above 90 degrees saturate to 90. Write only
// while no item is in flight.
// Reset (rst_n low, synchronous) clears the config registers and all valid
// bits; items in flight are dropped. The receiver cannot stall the output.
`include "cosine_law_angle_sampler_core_defines.svh"
module cosine_law_angle_sampler_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [31:0]               in_uniform_draw,
  output logic                      out_valid,
  output logic [cls_pkg::OUT_W-1:0] out_angle_out,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [cls_pkg::ANG_W-1:0] cfg_wdata
);

  localparam int STEPS = cls_pkg::BISECT_STEPS;
  localparam logic [cls_pkg::OUT_W-1:0] ANG90  = cls_pkg::OUT_W'(cls_pkg::DEG90);
  localparam logic [cls_pkg::OUT_W-1:0] ANG180 = cls_pkg::OUT_W'(cls_pkg::DEG180);

  logic [cls_pkg::ANG_W-1:0] angle_low_r;
  logic [cls_pkg::ANG_W-1:0] angle_high_r;
  logic                      flow_mode_r;
  logic                      backward_r;
  logic [cls_pkg::ANG_W-1:0] bound_clamp;
  logic                      accept;
  cls_pkg::side_t            front_side;
  logic                      lo_valid;
  logic [30:0]               lo_sine;
  logic [30:0]               lo_sq;
  cls_pkg::side_t            lo_side;
  logic                      hi_valid;
  logic [30:0]               hi_sine;
  logic [30:0]               hi_sq;
  cls_pkg::side_t            hi_side;
  logic [30:0]               lo_c;
  logic [30:0]               hi_c;
  logic                      d1_v_r;
  logic [30:0]               d1_lo_r;
  logic [30:0]               d1_diff_r;
  logic                      d1_up_r;
  logic [31:0]               d1_u_r;
  logic                      d2_v_r;
  logic [62:0]               d2_prod_r;
  logic [30:0]               d2_lo_r;
  logic                      d2_up_r;
  logic                      d3_v_r;
  cls_pkg::side_t            d3_side_r;
  cls_pkg::side_t            d3_side_nxt;
  logic [30:0]               step_amt;
  logic                      chain_v [STEPS+1];
  cls_pkg::side_t            chain_side [STEPS+1];
  logic                      out_valid_r;
  logic [cls_pkg::OUT_W-1:0] out_angle_r;

  // Configuration registers.
  assign bound_clamp = (cfg_wdata > cls_pkg::ANG_W'(cls_pkg::DEG90))
                     ? cls_pkg::ANG_W'(cls_pkg::DEG90) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_low_r  <= '0;
      angle_high_r <= '0;
      flow_mode_r  <= 1'b0;
      backward_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cls_pkg::cfg_idx_t'(cfg_index))
        cls_pkg::CFG_ANGLE_LOW:  angle_low_r  <= bound_clamp;
        cls_pkg::CFG_ANGLE_HIGH: angle_high_r <= bound_clamp;
        cls_pkg::CFG_FLOW_MODE:  flow_mode_r  <= cfg_wdata[0];
        cls_pkg::CFG_BACKWARD:   backward_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    front_side   = '0;
    front_side.u = in_uniform_draw;
  end

  // Curve values of both bounds.
  cls_curve u_curve_lo (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_angle   (angle_low_r),
    .in_side    (front_side),
    .out_valid  (lo_valid),
    .out_sine   (lo_sine),
    .out_sine_sq(lo_sq),
    .out_side   (lo_side)
  );

  cls_curve u_curve_hi (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_angle   (angle_high_r),
    .in_side    (front_side),
    .out_valid  (hi_valid),
    .out_sine   (hi_sine),
    .out_sine_sq(hi_sq),
    .out_side   (hi_side)
  );

  assign lo_c = flow_mode_r ? lo_sq : lo_sine;
  assign hi_c = flow_mode_r ? hi_sq : hi_sine;

  // Uniform draw between the two curve values, in three stages.
  assign step_amt = 31'(d2_prod_r >> 32);

  always_comb begin
    d3_side_nxt        = '0;
    d3_side_nxt.hi     = cls_pkg::ANG_W'(cls_pkg::DEG90);
    d3_side_nxt.target = d2_up_r ? d2_lo_r + step_amt : d2_lo_r - step_amt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
      d3_v_r <= 1'b0;
    end else begin
      d1_v_r <= lo_valid;
      d2_v_r <= d1_v_r;
      d3_v_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_lo_r   <= lo_c;
    d1_up_r   <= hi_c >= lo_c;
    d1_diff_r <= (hi_c >= lo_c) ? hi_c - lo_c : lo_c - hi_c;
    d1_u_r    <= lo_side.u;
    d2_prod_r <= 63'(d1_u_r) * 63'(d1_diff_r);
    d2_lo_r   <= d1_lo_r;
    d2_up_r   <= d1_up_r;
    d3_side_r <= d3_side_nxt;
  end

  // Bisection chain.
  assign chain_v[0]    = d3_v_r;
  assign chain_side[0] = d3_side_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cls_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .flow     (flow_mode_r),
      .in_valid (chain_v[i]),
      .in_side  (chain_side[i]),
      .out_valid(chain_v[i+1]),
      .out_side (chain_side[i+1])
    );
  end

  // Mirror for the backward hemisphere and register the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_v[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r <= backward_r
                 ? ANG180 - cls_pkg::OUT_W'(chain_side[STEPS].lo)
                 : cls_pkg::OUT_W'(chain_side[STEPS].lo);
  end

  assign out_valid     = out_valid_r;
  assign out_angle_out = out_angle_r;

  // The two bound pipelines run in step, and every result comes from an accepted item.
  `CLS_ASSERT_IMP(a_bnd_sync, hi_valid, lo_valid && (hi_side.u == lo_side.u), "lanes apart")
  `CLS_ASSERT_IMP(a_has_item, out_valid_r, $past(accept, cls_pkg::TOTAL_LAT), "no item")
  `CLS_ASSERT_IMP(a_angle_range, out_valid_r, out_angle_r <= ANG180, "angle over 180")
  `CLS_ASSERT_ALW(a_fwd_half, !out_valid_r || backward_r || (out_angle_r <= ANG90), "over 90")

endmodule

// ----- hdl/cls_curve.sv -----
// Pipelined Q30 sine and squared sine of an angle code, with side data.
module cls_curve (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [cls_pkg::ANG_W-1:0] in_angle,
  input  cls_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [30:0]               out_sine,
  output logic [30:0]               out_sine_sq,
  output cls_pkg::side_t            out_side
);

  localparam int NST = cls_pkg::CURVE_LAT;

  logic [NST-1:0]   vld_r;
  cls_pkg::side_t   side_r [NST];
  logic [30:0]      p1_r;
  logic [30:0]      p1b_r;
  logic [cls_pkg::W_P2-1:0] p2_r;
  logic [cls_pkg::N45-1:0]  n45;
  logic [cls_pkg::W_T-1:0]  t_r;
  logic [30:0]      x_r;
  logic [30:0]      x4_r;
  logic [31:0]      x2_r;
  logic [30:0]      term_w [9];
  logic [31:0]      sum_w [9];
  logic [31:0]      x2_w [8];
  logic [30:0]      s_r;
  logic [30:0]      s2_r;
  logic [30:0]      sq_r;

  // Valid bits and side data move one stage per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int i = 1; i < NST; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Radian conversion: integer part product and remainder product.
  assign n45 = cls_pkg::N45'(p2_r >> (cls_pkg::ANGLE_FRAC_BITS + 2));

  always_ff @(posedge clk) begin
    p1_r  <= 31'(in_angle) * 31'(cls_pkg::RAD_Q0);
    p2_r  <= cls_pkg::W_P2'(in_angle) * cls_pkg::W_P2'(cls_pkg::RAD_R0);
    t_r   <= cls_pkg::W_T'(n45) * cls_pkg::W_T'(cls_pkg::M45);
    p1b_r <= p1_r;
    x_r   <= p1b_r + 31'(t_r >> cls_pkg::S45);
    x2_r  <= 32'((62'(x_r) * 62'(x_r)) >> 30);
    x4_r  <= x_r;
  end

  assign term_w[0] = x4_r;
  assign sum_w[0]  = {1'b0, x4_r};
  assign x2_w[0]   = x2_r;

  // Taylor series: one term per two stages, multiply then divide.
  for (genvar k = 0; k < 8; k++) begin : g_tay
    logic [62:0] prod_r;
    logic [65:0] qm_r;
    logic [31:0] sa_r;
    logic [31:0] sb_r;
    logic [31:0] x2a_r;
    logic [31:0] x2b_r;

    always_ff @(posedge clk) begin
      prod_r <= 63'(term_w[k]) * 63'(x2_w[k]);
      sa_r   <= sum_w[k];
      x2a_r  <= x2_w[k];
      qm_r   <= 66'(32'((prod_r >> 30) >> cls_pkg::TAY_TZ[k]))
                * 66'(34'(cls_pkg::TAY_M[k]));
      sb_r   <= sa_r;
      x2b_r  <= x2a_r;
    end

    assign term_w[k+1] = 31'(qm_r >> cls_pkg::TAY_S[k]);

    // Every other term, starting with x^3, is subtracted, saturating at zero; the others are added.
    if ((k % 2) == 0) begin : g_sub
      assign sum_w[k+1] = ({1'b0, term_w[k+1]} > sb_r) ? '0 : sb_r - {1'b0, term_w[k+1]};
    end else begin : g_add
      assign sum_w[k+1] = sb_r + {1'b0, term_w[k+1]};
    end

    if (k < 7) begin : g_x2
      assign x2_w[k+1] = x2b_r;
    end
  end

  // Clamp to one, then square.
  always_ff @(posedge clk) begin
    s_r  <= (sum_w[8] > {1'b0, cls_pkg::ONE_Q30}) ? cls_pkg::ONE_Q30 : 31'(sum_w[8]);
    sq_r <= 31'((62'(s_r) * 62'(s_r)) >> 30);
    s2_r <= s_r;
  end

  assign out_valid   = vld_r[NST-1];
  assign out_side    = side_r[NST-1];
  assign out_sine    = s2_r;
  assign out_sine_sq = sq_r;

endmodule

// ----- hdl/cls_step.sv -----
// One bisection step of the inverse curve: probe the midpoint, narrow the range.
`include "cosine_law_angle_sampler_core_defines.svh"
module cls_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           flow,
  input  logic           in_valid,
  input  cls_pkg::side_t in_side,
  output logic           out_valid,
  output cls_pkg::side_t out_side
);

  logic [cls_pkg::ANG_W:0] span;
  logic                    v0_r;
  cls_pkg::side_t          s0_r;
  cls_pkg::side_t          s0_nxt;
  logic                    cv_valid;
  logic [30:0]             cv_sine;
  logic [30:0]             cv_sq;
  cls_pkg::side_t          cv_side;
  logic [30:0]             cv_val;
  cls_pkg::side_t          res_nxt;
  logic                    vout_r;
  cls_pkg::side_t          sout_r;

  // Midpoint rounded up.
  assign span = {1'b0, in_side.hi} - {1'b0, in_side.lo} + 1'b1;

  always_comb begin
    s0_nxt     = in_side;
    s0_nxt.mid = in_side.lo + cls_pkg::ANG_W'(span >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  cls_curve u_curve (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v0_r),
    .in_angle   (s0_r.mid),
    .in_side    (s0_r),
    .out_valid  (cv_valid),
    .out_sine   (cv_sine),
    .out_sine_sq(cv_sq),
    .out_side   (cv_side)
  );

  // Keep the midpoint if its curve value does not exceed the target.
  assign cv_val = flow ? cv_sq : cv_sine;

  always_comb begin
    res_nxt = cv_side;
    if (cv_val <= cv_side.target) begin
      res_nxt.lo = cv_side.mid;
    end else begin
      res_nxt.hi = cv_side.mid - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= cv_valid;
    end
  end

  always_ff @(posedge clk) begin
    sout_r <= res_nxt;
  end

  assign out_valid = vout_r;
  assign out_side  = sout_r;

  // The search range never inverts, and the probe lies inside it.
  `CLS_ASSERT_IMP(a_range_order, vout_r, sout_r.lo <= sout_r.hi, "bisection range inverted")
  `CLS_ASSERT_IMP(a_mid_inside, v0_r, (s0_r.mid >= s0_r.lo) && (s0_r.mid <= s0_r.hi), "probe outside range")

endmodule

// ----- tb/cosine_law_angle_sampler_core_tb.sv -----
// Self-checking testbench for the cosine-law polar angle sampler core.
`timescale 1ns / 1ps

module cosine_law_angle_sampler_core_tb;

  localparam int LATENCY = 434;
  localparam logic [63:0] BOUND_MAX = cls_pkg::DEG90;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_uniform_draw = '0;
  logic out_valid;
  logic [cls_pkg::OUT_W-1:0] out_angle_out;
  logic cfg_we = 1'b0;
  cls_pkg::cfg_idx_t cfg_index = cls_pkg::CFG_ANGLE_LOW;
  logic [cls_pkg::ANG_W-1:0] cfg_wdata = '0;

  // Shadow copy of the configuration as the sampler holds it.
  logic [cls_pkg::ANG_W-1:0] bound_low = '0;
  logic [cls_pkg::ANG_W-1:0] bound_high = '0;
  logic sin_squared = 1'b0;
  logic mirror = 1'b0;

  logic [31:0] draw_queue[$];
  logic [cls_pkg::OUT_W-1:0] angle_queue[$];
  int error_count = 0;
  int checked_count = 0;
  int gap_left = 0;
  int burst_left = 0;

  cosine_law_angle_sampler_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_uniform_draw(in_uniform_draw), .out_valid(out_valid),
    .out_angle_out(out_angle_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Sine of an angle code in Q30 by a truncated Taylor series.
  function automatic longint unsigned sine_q30(longint unsigned ang);
    longint unsigned x, x2, term, sum;
    x = (ang * cls_pkg::PI_Q30) / cls_pkg::DEG180;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = (term > sum) ? 0 : sum - term;
      else sum = sum + term;
    end
    return (sum > 64'(cls_pkg::ONE_Q30)) ? 64'(cls_pkg::ONE_Q30) : sum;
  endfunction

  function automatic longint unsigned curve_q30(longint unsigned ang, logic sq);
    longint unsigned s;
    s = sine_q30(ang);
    return sq ? ((s * s) >> 30) : s;
  endfunction

  // Expected angle for one uniform draw under the current configuration.
  function automatic logic [cls_pkg::OUT_W-1:0] sampled_angle(logic [31:0] u);
    longint unsigned lo_v, hi_v, target, a_lo, a_hi, mid;
    lo_v = curve_q30(bound_low, sin_squared);
    hi_v = curve_q30(bound_high, sin_squared);
    if (hi_v >= lo_v) target = lo_v + ((64'(u) * (hi_v - lo_v)) >> 32);
    else target = lo_v - ((64'(u) * (lo_v - hi_v)) >> 32);
    a_lo = 0;
    a_hi = cls_pkg::DEG90;
    while (a_lo < a_hi) begin
      mid = a_lo + (a_hi - a_lo + 1) / 2;
      if (curve_q30(mid, sin_squared) <= target) a_lo = mid;
      else a_hi = mid - 1;
    end
    if (mirror) a_lo = cls_pkg::DEG180 - a_lo;
    return a_lo[cls_pkg::OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Appends one uniform draw to the pending items.
  task automatic queue_draw(logic [31:0] v);
    draw_queue = {draw_queue, v};
  endtask

  // Driver: sends queued items in bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) angle_queue = {angle_queue, sampled_angle(in_uniform_draw)};
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (draw_queue.size() > 0) begin
          start <= 1'b1;
          in_uniform_draw <= draw_queue.pop_front();
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed angle must match the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (angle_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected angle %0d", out_angle_out));
      end else begin
        if (out_angle_out !== angle_queue[0])
          report_mismatch($sformatf("angle %0d, expected %0d", out_angle_out,
                                    angle_queue[0]));
        void'(angle_queue.pop_front());
        checked_count++;
      end
    end
  end

  // Waits until every queued item has gone in and every angle has come out.
  task automatic wait_drained();
    do @(posedge clk);
    while (draw_queue.size() > 0 || start || angle_queue.size() > 0);
  endtask

  // Writes all four registers while nothing is in flight.
  task automatic configure(logic [cls_pkg::ANG_W-1:0] lo, logic [cls_pkg::ANG_W-1:0] hi,
                           logic sq, logic bw);
    logic [cls_pkg::ANG_W-1:0] vals[4];
    vals = '{lo, hi, cls_pkg::ANG_W'(sq), cls_pkg::ANG_W'(bw)};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cls_pkg::cfg_idx_t'(i);
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    bound_low = (64'(lo) > BOUND_MAX) ? cls_pkg::ANG_W'(BOUND_MAX) : lo;
    bound_high = (64'(hi) > BOUND_MAX) ? cls_pkg::ANG_W'(BOUND_MAX) : hi;
    sin_squared = sq;
    mirror = bw;
  endtask

  task automatic queue_directed();
    logic [31:0] picks[8];
    picks = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF,
              32'h4000_0000, 32'hC000_0000, 32'hAAAA_5555};
    foreach (picks[i]) queue_draw(picks[i]);
  endtask

  initial begin
    logic [cls_pkg::ANG_W-1:0] lo, hi;
    // Reset, then the power-up configuration with directed draws.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed();
    // Full range both modes and directions, reversed bounds, bounds above ninety.
    configure('0, cls_pkg::ANG_W'(BOUND_MAX), 1'b0, 1'b0);
    queue_directed();
    configure('0, cls_pkg::ANG_W'(BOUND_MAX), 1'b1, 1'b1);
    queue_directed();
    configure(cls_pkg::ANG_W'(BOUND_MAX), 17'd1024, 1'b0, 1'b1);
    queue_directed();
    configure('1, 17'd92161, 1'b1, 1'b0);
    queue_directed();
    configure(17'd30720, 17'd30720, 1'b0, 1'b0);
    queue_directed();

    // Random settings, each with a run of random draws.
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(0, 3))
        0: begin lo = '0; hi = cls_pkg::ANG_W'(BOUND_MAX); end
        1: begin
          lo = cls_pkg::ANG_W'($urandom_range(0, 131071));
          hi = cls_pkg::ANG_W'($urandom_range(0, 131071));
        end
        default: begin
          lo = cls_pkg::ANG_W'($urandom_range(0, 92160));
          hi = cls_pkg::ANG_W'($urandom_range(0, 92160));
        end
      endcase
      configure(lo, hi, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 170; i++) begin
        case ($urandom_range(0, 9))
          0: queue_draw(32'($urandom_range(0, 255)));
          1: queue_draw(32'hFFFF_FFFF - 32'($urandom_range(0, 255)));
          default: queue_draw($urandom);
        endcase
      end
    end

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d angles over directed and random bound, flow-mode",
             checked_count);
    $display("and direction settings, including saturated and reversed bounds.");
    if (error_count == 0 && angle_queue.size() == 0) begin
      $display("cosine_law_angle_sampler_core_tb: done, clean");
    end else begin
      $display("cosine_law_angle_sampler_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung run.
  initial begin
    #5_000_000;
    $display("cosine_law_angle_sampler_core_tb: done, errors");
    $finish;
  end

endmodule
